### hdl/vmeg_pkg.sv
package vmeg_pkg;

    localparam int MaxVoices  = 64;
    localparam int SampleBits = 24;
    localparam int CountBits  = $clog2(MaxVoices + 1);

    localparam int unsigned GainOne = 65536;
    localparam int unsigned GainMin = 6554;
    localparam int unsigned AudibleMin = 838;

    // Configuration register indexes.
    localparam logic [1:0] CfgLowEnergy = 2'd0;
    localparam logic [1:0] CfgSatThresh = 2'd1;
    localparam logic [1:0] CfgStrength  = 2'd2;

    // One accumulated period handed from the front part to the back part.
    typedef struct packed {
        logic signed [31:0] sum_left;
        logic signed [31:0] sum_right;
        logic [31:0]        sum_energy;
    } vmeg_period_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_BLEND,
        ST_CLAMP,
        ST_CH_MUL,
        ST_CH_ROUND,
        ST_CH_TANH,
        ST_CH_INTERP,
        ST_CH_SAT,
        ST_CH_DONE,
        ST_OUT
    } vmeg_state_t;

    // Q.16 tanh table at steps of 1/8 over [0, 4].
    function automatic logic [16:0] tanh_lut(input logic [5:0] idx);
        logic [16:0] v;
        case (idx)
            6'd0: v = 17'd0;      6'd1: v = 17'd8150;   6'd2: v = 17'd16051;
            6'd3: v = 17'd23485;  6'd4: v = 17'd30285;  6'd5: v = 17'd36346;
            6'd6: v = 17'd41625;  6'd7: v = 17'd46131;  6'd8: v = 17'd49912;
            6'd9: v = 17'd53038;  6'd10: v = 17'd55593; 6'd11: v = 17'd57660;
            6'd12: v = 17'd59320; 6'd13: v = 17'd60643; 6'd14: v = 17'd61694;
            6'd15: v = 17'd62524; 6'd16: v = 17'd63179; 6'd17: v = 17'd63693;
            6'd18: v = 17'd64096; 6'd19: v = 17'd64412; 6'd20: v = 17'd64659;
            6'd21: v = 17'd64852; 6'd22: v = 17'd65003; 6'd23: v = 17'd65120;
            6'd24: v = 17'd65212; 6'd25: v = 17'd65283; 6'd26: v = 17'd65339;
            6'd27: v = 17'd65383; 6'd28: v = 17'd65417; 6'd29: v = 17'd65443;
            6'd30: v = 17'd65464; 6'd31: v = 17'd65480;
            default: v = 17'd65492;
        endcase
        return v;
    endfunction

endpackage

### hdl/vmeg_if.sv
interface vmeg_voice_if;
    logic valid;
    logic ready;
    logic signed [23:0] voice_left;
    logic signed [23:0] voice_right;
    logic [23:0] voice_energy;
    logic voice_active;
    logic last_voice;

    modport source (output valid, voice_left, voice_right, voice_energy, voice_active,
                    last_voice, input ready);
    modport sink (input valid, voice_left, voice_right, voice_energy, voice_active,
                  last_voice, output ready);
endinterface

interface vmeg_result_if;
    logic valid;
    logic ready;
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic [16:0] applied_gain;
    logic [31:0] sample_energy;
    logic audible;

    modport source (output valid, out_left, out_right, applied_gain, sample_energy,
                    audible, input ready);
    modport sink (input valid, out_left, out_right, applied_gain, sample_energy,
                  audible, output ready);
endinterface

### hdl/vmeg_front.sv
module vmeg_front (
    input  logic                  clk,
    input  logic                  rst_n,
    vmeg_voice_if.sink            voice,
    output logic                  push,
    output vmeg_pkg::vmeg_period_t push_data,
    input  logic                  full
);
    import vmeg_pkg::*;

    logic signed [31:0] sum_left_reg, sum_left_next;
    logic signed [31:0] sum_right_reg, sum_right_next;
    logic [31:0] sum_energy_reg, sum_energy_next;
    logic [CountBits-1:0] count_reg, count_next;
    logic accept;
    logic signed [32:0] add_l, add_r;
    logic [32:0] add_e;

    assign voice.ready = !full;
    assign accept = voice.valid && voice.ready;

    // Saturating accumulation of active voices.
    always_comb
    begin
        add_l = 33'(sum_left_reg) + 33'(voice.voice_left);
        add_r = 33'(sum_right_reg) + 33'(voice.voice_right);
        add_e = {1'b0, sum_energy_reg} + 33'(voice.voice_energy);
        sum_left_next = sum_left_reg;
        sum_right_next = sum_right_reg;
        sum_energy_next = sum_energy_reg;
        count_next = count_reg;
        if (count_reg < CountBits'(MaxVoices))
        begin
            count_next = count_reg + 1'b1;
            if (voice.voice_active)
            begin
                sum_left_next = (add_l > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                                (add_l < -33'sh080000000) ? 32'sh80000000 : add_l[31:0];
                sum_right_next = (add_r > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                                 (add_r < -33'sh080000000) ? 32'sh80000000 : add_r[31:0];
                sum_energy_next = add_e[32] ? 32'hFFFFFFFF : add_e[31:0];
            end
        end
        push_data.sum_left = sum_left_next;
        push_data.sum_right = sum_right_next;
        push_data.sum_energy = sum_energy_next;
        push = accept && voice.last_voice;
    end

    // Accumulator registers, cleared after each finished period.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_left_reg <= '0;
            sum_right_reg <= '0;
            sum_energy_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            if (voice.last_voice)
            begin
                sum_left_reg <= '0;
                sum_right_reg <= '0;
                sum_energy_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_left_reg <= sum_left_next;
                sum_right_reg <= sum_right_next;
                sum_energy_reg <= sum_energy_next;
                count_reg <= count_next;
            end
        end
    end
endmodule

### hdl/vmeg_queue.sv
module vmeg_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  vmeg_pkg::vmeg_period_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output vmeg_pkg::vmeg_period_t pop_data
);
    import vmeg_pkg::*;

    vmeg_period_t mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage for two pending periods.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### hdl/vmeg_back.sv
module vmeg_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   not_empty,
    input  vmeg_pkg::vmeg_period_t pop_data,
    output logic                   pop,
    input  logic [23:0]            low_thr,
    input  logic [22:0]            sat_thr,
    input  logic [17:0]            strength,
    vmeg_result_if.source          result
);
    import vmeg_pkg::*;

    vmeg_state_t state_reg, state_next;
    vmeg_period_t per_reg;
    logic [5:0] step_reg;
    logic [48:0] rem_reg;
    logic [48:0] quo_reg;
    logic [49:0] sq_x_reg;
    logic [49:0] sq_res_reg;
    logic [16:0] gain_reg;
    logic signed [44:0] blend_reg;
    logic ch_reg;
    logic neg_reg;
    logic [31:0] mag_reg;
    logic [48:0] prod_reg;
    logic [32:0] gmag_reg;
    logic [33:0] x_reg;
    logic [16:0] th_reg;
    logic [16:0] d_reg;
    logic [19:0] frac_reg;
    logic [23:0] res_l_reg, res_r_reg;
    logic loud_reg;
    logic out_valid_reg;

    logic [49:0] div_trial;
    logic [49:0] sq_trial;
    logic [49:0] sq_src;
    logic signed [44:0] blend_t;
    logic signed [44:0] blend_min;
    logic [5:0] k;
    logic [36:0] ip;
    logic [16:0] th_full;
    logic [40:0] sat_prod;
    logic [55:0] sat_mul;
    logic [23:0] sat_q;
    logic [24:0] r_sum;
    logic [23:0] r_mag;
    logic [23:0] r_out;
    logic signed [31:0] ch_sum;

    assign ch_sum = ch_reg ? per_reg.sum_right : per_reg.sum_left;
    assign div_trial = {rem_reg, 1'b0} + 50'(quo_reg[48] ? 1'b0 : 1'b0);
    assign sq_trial = sq_res_reg + (50'd1 << {step_reg, 1'b0});
    assign sq_src = (step_reg == 6'd24) ? 50'(quo_reg) : sq_x_reg;
    assign blend_t = blend_reg + 45'sh100000000;
    assign blend_min = $signed(45'(GainMin) << 16);
    assign k = 6'(x_reg[24:20]);
    assign ip = 37'(d_reg) * 37'(frac_reg) + (37'd1 << 19);
    assign th_full = th_reg + 17'(ip >> 20);
    // th * 2^23 / 655360 rounded = (th * 128 + 5) / 10 floored.
    // The division by ten is a reciprocal multiply, exact for this 24-bit operand.
    assign sat_prod = 41'(th_reg) * 41'd128 + 41'd5;
    assign sat_mul = 56'(sat_prod[23:0]) * 56'hCCCCCCCD;
    assign sat_q = 24'(sat_mul >> 35);
    assign r_sum = 25'(sat_thr) + 25'(sat_q);
    assign r_mag = (gmag_reg <= 33'(sat_thr)) ? gmag_reg[23:0] :
                   (r_sum > 25'h800000) ? 24'h800000 : r_sum[23:0];
    assign r_out = (!neg_reg && r_mag > 24'h7FFFFF) ? 24'h7FFFFF :
                   (neg_reg ? -r_mag : r_mag);

    assign pop = (state_reg == ST_IDLE) && not_empty && !out_valid_reg;
    assign result.valid = out_valid_reg;
    assign result.out_left = res_l_reg;
    assign result.out_right = res_r_reg;
    assign result.applied_gain = gain_reg;
    assign result.sample_energy = per_reg.sum_energy;
    assign result.audible = loud_reg;

    // Sequencer: divide, root, blend, clamp, each channel; low energy skips to channels.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (pop) state_next = ST_DIV;
            ST_DIV:       if (per_reg.sum_energy <= 32'(low_thr) || per_reg.sum_energy == 0)
                              state_next = ST_CH_MUL;
                          else if (step_reg == 6'd48) state_next = ST_SQRT;
            ST_SQRT:      if (step_reg == 6'd0) state_next = ST_BLEND;
            ST_BLEND:     state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_CH_MUL;
            ST_CH_MUL:    state_next = ST_CH_ROUND;
            ST_CH_ROUND:  state_next = ST_CH_TANH;
            ST_CH_TANH:   state_next = ST_CH_INTERP;
            ST_CH_INTERP: state_next = ST_CH_SAT;
            ST_CH_SAT:    state_next = ST_CH_DONE;
            ST_CH_DONE:   state_next = ch_reg ? ST_OUT : ST_CH_MUL;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                // Load a new period only when one is taken, so a waiting result holds.
                if (pop)
                begin
                    per_reg <= pop_data;
                    step_reg <= '0;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    gain_reg <= 17'(GainOne);
                    ch_reg <= 1'b0;
                    loud_reg <= 1'b0;
                end
            end
            ST_DIV:
            begin
                // Restoring division of 2^48 by the energy, one bit a cycle.
                if (div_trial[48:0] + ((step_reg == 6'd0) ? 49'd1 : 49'd0) >=
                    49'(per_reg.sum_energy))
                begin
                    rem_reg <= div_trial[48:0] + ((step_reg == 6'd0) ? 49'd1 : 49'd0)
                               - 49'(per_reg.sum_energy);
                    quo_reg <= {quo_reg[47:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_trial[48:0] + ((step_reg == 6'd0) ? 49'd1 : 49'd0);
                    quo_reg <= {quo_reg[47:0], 1'b0};
                end
                if (step_reg == 6'd48)
                begin
                    step_reg <= 6'd24;
                    sq_res_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
                sq_x_reg <= '0;
            end
            ST_SQRT:
            begin
                // Digit-by-digit square root, one result bit a cycle.
                if (sq_src >= sq_trial)
                begin
                    sq_x_reg <= sq_src - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + (50'd1 << {step_reg, 1'b0});
                end
                else
                begin
                    sq_x_reg <= sq_src;
                    sq_res_reg <= sq_res_reg >> 1;
                end
                if (step_reg != 6'd0)
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
            ST_BLEND:
            begin
                blend_reg <= 45'(signed'({1'b0, strength})) *
                             (45'(signed'({1'b0, sq_res_reg[24:0]})) - 45'sd65536);
            end
            ST_CLAMP:
            begin
                if (blend_reg >= 0)
                    gain_reg <= 17'(GainOne);
                else if (blend_t < blend_min)
                    gain_reg <= 17'(GainMin);
                else
                    gain_reg <= 17'(blend_t >>> 16);
            end
            ST_CH_MUL:
            begin
                neg_reg <= ch_sum[31];
                mag_reg <= ch_sum[31] ? 32'(-33'(ch_sum)) : ch_sum;
            end
            ST_CH_ROUND:
            begin
                prod_reg <= 49'(mag_reg) * 49'(gain_reg) + 49'd32768;
            end
            ST_CH_TANH:
            begin
                gmag_reg <= 33'(prod_reg >> 16);
                x_reg <= (34'(prod_reg >> 16) - 34'(sat_thr)) << 1;
            end
            ST_CH_INTERP:
            begin
                // Arguments of 4 and above take the last table value.
                if (x_reg[33:25] != '0)
                begin
                    th_reg <= tanh_lut(6'd32);
                    d_reg <= '0;
                end
                else
                begin
                    th_reg <= tanh_lut(k);
                    d_reg <= tanh_lut(k + 1'b1) - tanh_lut(k);
                end
                frac_reg <= x_reg[19:0];
            end
            ST_CH_SAT:
            begin
                th_reg <= th_full;
                d_reg <= '0;
            end
            ST_CH_DONE:
            begin
                if (ch_reg)
                    res_r_reg <= r_out;
                else
                    res_l_reg <= r_out;
                if (r_mag > 24'(AudibleMin))
                    loud_reg <= 1'b1;
                ch_reg <= 1'b1;
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule

### hdl/voice_mixer_energy_gain.sv
// Channel   Direction  Carries
// voice     in         one voice: samples, energy, active flag, last-voice flag
// result    out        mixed stereo sample, applied gain, period energy, audible flag
// cfg       in         register writes: cfg_we, cfg_index, cfg_data
//
// Voices are accepted one per cycle unless the queue is full; a two-entry queue holds
// finished periods. The back part pops a period, divides, takes the square root, blends,
// clamps, runs multiply, round, tanh, interpolate, saturate and done per channel, outputs;
// at or below the unity threshold it goes from divide to the channels. The back part takes
// no new period while a result waits. Reset clears sums, queue and sequencer; registers
// return to defaults. The voice side stalls only while the queue is full.
module voice_mixer_energy_gain (
    input  logic        clk,
    input  logic        rst_n,
    vmeg_voice_if.sink  voice,
    vmeg_result_if.source result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import vmeg_pkg::*;

    logic [23:0] low_thr_reg;
    logic [22:0] sat_thr_reg;
    logic [17:0] strength_reg;
    logic push, full, pop, not_empty;
    vmeg_period_t push_data, pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg <= 24'd6554;
            sat_thr_reg <= 23'd7549747;
            strength_reg <= 18'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgLowEnergy: low_thr_reg <= cfg_data;
                CfgSatThresh: sat_thr_reg <= cfg_data[22:0];
                CfgStrength:  strength_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    vmeg_front u_front (
        .clk(clk), .rst_n(rst_n), .voice(voice),
        .push(push), .push_data(push_data), .full(full)
    );

    vmeg_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
    );

    vmeg_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .pop_data(pop_data), .pop(pop),
        .low_thr(low_thr_reg), .sat_thr(sat_thr_reg), .strength(strength_reg),
        .result(result)
    );
endmodule

### sim/voice_mixer_energy_gain_test.sv
`timescale 1ns / 1ps

module voice_mixer_energy_gain_test;
    import vmeg_pkg::*;

    localparam int CyclesLimit = 1000000;
    localparam int SettleCycles = 200;
    localparam longint unsigned OneQ23 = 64'd8388608;

    // Q.16 tanh samples at steps of 1/8 over [0, 4].
    localparam longint TanhQ16 [33] = '{
        0, 8150, 16051, 23485, 30285, 36346, 41625, 46131, 49912,
        53038, 55593, 57660, 59320, 60643, 61694, 62524, 63179,
        63693, 64096, 64412, 64659, 64852, 65003, 65120, 65212,
        65283, 65339, 65383, 65417, 65443, 65464, 65480, 65492
    };

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [16:0]        gain;
        logic [31:0]        energy;
        logic               audible;
    } mix_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [23:0] cfg_data;

    vmeg_voice_if voice ();
    vmeg_result_if result ();

    voice_mixer_energy_gain dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .voice     (voice.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block's registers and running sums.
    longint unsigned low_energy_thr;
    longint unsigned sat_thr;
    longint unsigned strength;
    longint mix_left;
    longint mix_right;
    longint unsigned mix_energy;
    int unsigned voices_seen;

    mix_result_t pending_mixes[$];

    bit idle_on;
    int hold_req;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned mixes_checked;
    int unsigned periods_saturated;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CyclesLimit)
        begin
            $display("Run limit of %0d cycles reached, %0d results outstanding",
                     CyclesLimit, pending_mixes.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > x)
        begin
            bitpos >>= 2;
        end
        while (bitpos != 0)
        begin
            if (x >= root + bitpos)
            begin
                x -= root + bitpos;
                root = (root >> 1) + bitpos;
            end
            else
            begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    // Gain from period energy: unity at low energy, else blended inverse root.
    function automatic longint energy_gain(input longint unsigned e);
        longint base;
        longint t;
        if (e <= low_energy_thr || e == 0)
            return longint'(GainOne);
        base = longint'(int_sqrt((64'd1 << 48) / e));
        t = longint'(GainOne) * longint'(GainOne)
            + longint'(strength) * (base - longint'(GainOne));
        if (t >= longint'(GainOne) * longint'(GainOne))
            return longint'(GainOne);
        if (t < longint'(GainMin) * longint'(GainOne))
            return longint'(GainMin);
        return t / longint'(GainOne);
    endfunction

    // Soft saturation above the threshold with an interpolated tanh curve.
    function automatic longint unsigned soft_clip(input longint unsigned mag);
        longint unsigned x;
        longint unsigned k;
        longint unsigned frac;
        longint unsigned delta;
        longint unsigned th;
        longint unsigned r;
        if (mag <= sat_thr)
            return mag;
        x = 2 * (mag - sat_thr);
        k = x >> 20;
        if (k >= 32)
        begin
            th = TanhQ16[32];
        end
        else
        begin
            frac = x & ((64'd1 << 20) - 1);
            delta = TanhQ16[k + 1] - TanhQ16[k];
            th = TanhQ16[k] + ((delta * frac + (64'd1 << 19)) >> 20);
        end
        r = sat_thr + (th * OneQ23 + 327680) / 655360;
        if (r > OneQ23)
            r = OneQ23;
        return r;
    endfunction

    function automatic logic [23:0] shape_channel(input longint sum, input longint gain,
                                                  inout logic loud);
        logic neg;
        longint unsigned mag;
        neg = sum < 0;
        mag = neg ? longint'(-sum) : sum;
        mag = (mag * longint'(gain) + 32768) >> 16;
        mag = soft_clip(mag);
        if (!neg && mag > OneQ23 - 1)
            mag = OneQ23 - 1;
        if (mag > AudibleMin)
            loud = 1'b1;
        if (neg)
            mag = 64'd0 - mag;
        return mag[23:0];
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Accumulate one accepted voice; close the period on the last voice.
    function automatic void mix_voice(input logic signed [23:0] l, input logic signed [23:0] r,
                                      input logic [23:0] e, input logic act, input logic last);
        mix_result_t res;
        longint gain;
        logic loud;
        if (voices_seen < MaxVoices)
        begin
            if (act)
            begin
                mix_left = clamp32(mix_left + longint'(l));
                mix_right = clamp32(mix_right + longint'(r));
                mix_energy += e;
                if (mix_energy > 64'hFFFF_FFFF)
                    mix_energy = 64'hFFFF_FFFF;
            end
            voices_seen++;
        end
        if (!last)
            return;
        loud = 1'b0;
        gain = energy_gain(mix_energy);
        res.left = shape_channel(mix_left, gain, loud);
        res.right = shape_channel(mix_right, gain, loud);
        res.gain = gain[16:0];
        res.energy = mix_energy[31:0];
        res.audible = loud;
        if (res.left == 24'h7FFFFF || res.left == 24'h800000)
            periods_saturated++;
        pending_mixes.push_back(res);
        mix_left = 0;
        mix_right = 0;
        mix_energy = 0;
        voices_seen = 0;
    endfunction

    // Receiver: random stall bursts, and long hold-offs on request.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            if (hold_req > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each delivered result with the oldest expected one.
    always @(posedge clk)
    begin
        mix_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_mixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result at cycle %0d: L=%0d R=%0d", cycle_count,
                             result.out_left, result.out_right);
            end
            else
            begin
                want = pending_mixes.pop_front();
                mixes_checked++;
                if (result.out_left !== want.left || result.out_right !== want.right
                    || result.applied_gain !== want.gain
                    || result.sample_energy !== want.energy
                    || result.audible !== want.audible)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch at cycle %0d: expected L=%0d R=%0d G=%0d E=%0d A=%0d,",
                                 cycle_count, want.left, want.right, want.gain, want.energy,
                                 want.audible);
                        $display("    got L=%0d R=%0d G=%0d E=%0d A=%0d",
                                 result.out_left, result.out_right, result.applied_gain,
                                 result.sample_energy, result.audible);
                    end
                end
            end
        end
    end

    // Send one voice request and wait until it is taken.
    task automatic send_voice(input logic signed [23:0] l, input logic signed [23:0] r,
                              input logic [23:0] e, input logic act, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            voice.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        voice.valid <= 1'b1;
        voice.voice_left <= l;
        voice.voice_right <= r;
        voice.voice_energy <= e;
        voice.voice_active <= act;
        voice.last_voice <= last;
        do
            @(posedge clk);
        while (!voice.ready);
        mix_voice(l, r, e, act, last);
        requests_sent++;
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic drain_results();
        voice.valid <= 1'b0;
        while (pending_mixes.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Write all three registers while the block is idle.
    task automatic set_config(input logic [23:0] low_e, input logic [23:0] sat,
                              input logic [23:0] strg);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= CfgLowEnergy;
        cfg_data <= low_e;
        @(posedge clk);
        cfg_index <= CfgSatThresh;
        cfg_data <= sat;
        @(posedge clk);
        cfg_index <= CfgStrength;
        cfg_data <= strg;
        @(posedge clk);
        cfg_we <= 1'b0;
        low_energy_thr = low_e;
        sat_thr = sat & 24'h7FFFFF;
        strength = strg & 24'h03FFFF;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 4096))
                                           : 24'(24'h800000 + $urandom_range(0, 4096));
            default: return 24'($signed(24'($urandom)) >>> 3);
        endcase
    endfunction

    function automatic logic [23:0] pick_energy();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 8192));
            1: return 24'($urandom);
            2: return 24'd0;
            default: return 24'($urandom_range(32768, 131072));
        endcase
    endfunction

    // One well-formed period with random content, occasionally malformed.
    task automatic send_period(input int voices);
        for (int i = 0; i < voices; i++)
            send_voice(pick_sample(), pick_sample(), pick_energy(),
                       $urandom_range(0, 5) != 0,
                       (i == voices - 1) || ($urandom_range(0, 40) == 0));
    endtask

    task automatic test_directed();
        // Full-scale single voices at unity gain.
        send_voice(24'sh7FFFFF, 24'sh800000, 24'd0, 1'b1, 1'b1);
        send_voice(24'sh800000, 24'sh7FFFFF, 24'd0, 1'b1, 1'b1);
        // A period with no active voice.
        send_voice(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        send_voice(24'sh800000, 24'sh800000, 24'hFFFFFF, 1'b0, 1'b1);
        // Energy right at the unity threshold and one above.
        send_voice(24'sd4000000, -24'sd4000000, 24'd6554, 1'b1, 1'b1);
        send_voice(24'sd4000000, -24'sd4000000, 24'd6555, 1'b1, 1'b1);
        // Right at and just over the audible level.
        send_voice(24'sd838, -24'sd838, 24'd0, 1'b1, 1'b1);
        send_voice(24'sd839, 24'sd0, 24'd0, 1'b1, 1'b1);
        send_voice(24'sd0, -24'sd839, 24'd0, 1'b1, 1'b1);
        // Loud multi-voice sum with maximum energy, driving the gain floor.
        for (int i = 0; i < 4; i++)
            send_voice(24'sh7FFFFF, 24'sh800000, 24'hFFFFFF, 1'b1, i == 3);
        // Inactive last voice closing an active period.
        send_voice(24'sd1000000, 24'sd2000000, 24'd70000, 1'b1, 1'b0);
        send_voice(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF, 1'b0, 1'b1);
        // Energy near one, where the inverse root is close to unity.
        send_voice(24'sd6000000, 24'sd8000000, 24'd65536, 1'b1, 1'b1);
        send_voice(24'sd6000000, 24'sd8000000, 24'd65537, 1'b1, 1'b1);
    endtask

    task automatic test_voice_overflow();
        // More voices than the block counts; the last one still closes.
        for (int i = 0; i < MaxVoices + 6; i++)
            send_voice(24'sh7FFFFF, 24'sh800000, 24'd200000, 1'b1, i == MaxVoices + 5);
        for (int i = 0; i < MaxVoices + 1; i++)
            send_voice(pick_sample(), pick_sample(), pick_energy(), 1'b1, i == MaxVoices);
    endtask

    task automatic test_random_periods(input int items);
        int target;
        target = requests_sent + items;
        while (requests_sent < target)
            send_period($urandom_range(1, 8));
    endtask

    task automatic test_config_extremes();
        set_config(24'd0, 24'd0, 24'd0);
        test_random_periods(150);
        set_config(24'hFFFFFF, 24'h7FFFFF, 24'd131072);
        test_random_periods(100);
        set_config(24'd0, 24'd0, 24'd131072);
        test_random_periods(150);
        set_config(24'd65536, 24'd4194304, 24'd32768);
        test_random_periods(150);
        set_config(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'h7FFFFF)),
                   24'($urandom_range(0, 131072)));
        test_random_periods(150);
        set_config(24'd6554, 24'd7549747, 24'd65536);
    endtask

    task automatic test_backpressure();
        // Hold the receiver off so the period queue fills and voices stall.
        hold_req = 400;
        for (int i = 0; i < 40; i++)
            send_voice(pick_sample(), pick_sample(), pick_energy(), 1'b1, i % 2 == 1);
        drain_results();
    endtask

    initial
    begin
        voice.valid <= 1'b0;
        voice.voice_left <= '0;
        voice.voice_right <= '0;
        voice.voice_energy <= '0;
        voice.voice_active <= 1'b0;
        voice.last_voice <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CfgLowEnergy;
        cfg_data <= '0;
        rst_n = 1'b0;
        idle_on = 1'b1;
        hold_req = 0;
        low_energy_thr = 6554;
        sat_thr = 7549747;
        strength = 65536;
        mix_left = 0;
        mix_right = 0;
        mix_energy = 0;
        voices_seen = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_voice_overflow();
        test_backpressure();
        test_config_extremes();
        test_random_periods(250);
        idle_on = 1'b0;
        test_random_periods(150);

        drain_results();
        $display("Sent %0d voice requests, checked %0d mixed results (%0d at full scale)",
                 requests_sent, mixes_checked, periods_saturated);
        $display("Covered register extremes, voice overflow, long stalls and idle gaps");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
